>>> hw/rtl/bffa_pkg.sv
`default_nettype none

package bffa_pkg;

    // Field widths fixed by the transaction format
    localparam int ADDR_W   = 16;
    localparam int SIZE_W   = 17;
    localparam int MODE_W   = 2;

    // Buffer ceiling and allocation granule
    localparam int BUF_BYTES     = 65536;
    localparam int MIN_BLOCK     = 16;
    localparam int MAX_SEGMENTS_DEF = 64;

    // Stream payload widths (zero padded to whole bytes)
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NOP   = 2'd3
    } mode_t;

    // One free segment of the table
    typedef struct packed {
        logic [SIZE_W-1:0] len;
        logic [ADDR_W-1:0] start;
    } seg_t;

    // Datapath command, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_FAIL,
        OP_CLEAR_OK,
        OP_SCAN_INIT,
        OP_SCAN,
        OP_ALLOC_FIN,
        OP_FREE_A,
        OP_FREE_B,
        OP_FREE_C,
        OP_FREE_D,
        OP_SHIFT_DN,
        OP_SHIFT_UP,
        OP_PUSH
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        mode_t mode;
        logic  alloc_room;
        logic  free_in_range;
        logic  scan_done;
        logic  found;
        logic  drop;
        logic  merge_l;
        logic  merge_r;
        logic  full;
        logic  shift_done;
        logic  out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/bffa_ctrl.sv
`default_nettype none

module bffa_ctrl
    import bffa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire logic     cfg_wr_en,
    input  wire dp_stat_t stat,
    output dp_op_t        op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISP,
        S_SCAN,
        S_ALLOC,
        S_FA,
        S_FB,
        S_FC,
        S_FD,
        S_SHDN,
        S_SHUP,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   clr_pend_reg, clr_pend_next;

    // Next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        op            = OP_NONE;
        clr_pend_next = clr_pend_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (clr_pend_reg)
                begin
                    op            = OP_CLEAR;
                    clr_pend_next = 1'b0;
                end
                else if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.mode)
                    MODE_ALLOC:
                    begin
                        if (stat.alloc_room)
                        begin
                            op         = OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            op         = OP_FAIL;
                            state_next = S_RESP;
                        end
                    end
                    MODE_FREE:
                    begin
                        if (stat.free_in_range)
                        begin
                            op         = OP_SCAN_INIT;
                            state_next = S_SCAN;
                        end
                        else
                        begin
                            op         = OP_FAIL;
                            state_next = S_RESP;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        op         = OP_CLEAR_OK;
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        op         = OP_FAIL;
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SCAN:
            begin
                op = OP_SCAN;
                if (stat.scan_done)
                    state_next = (stat.mode == MODE_FREE) ? S_FA : S_ALLOC;
            end
            S_ALLOC:
            begin
                op         = OP_ALLOC_FIN;
                state_next = (stat.found && stat.drop) ? S_SHDN : S_RESP;
            end
            S_FA:
            begin
                op         = OP_FREE_A;
                state_next = S_FB;
            end
            S_FB:
            begin
                op         = OP_FREE_B;
                state_next = S_FC;
            end
            S_FC:
            begin
                op         = OP_FREE_C;
                state_next = S_FD;
            end
            S_FD:
            begin
                op = OP_FREE_D;
                if (stat.full)
                    state_next = S_RESP;
                else if (stat.merge_l && stat.merge_r)
                    state_next = S_SHDN;
                else if (!stat.merge_l && !stat.merge_r)
                    state_next = S_SHUP;
                else
                    state_next = S_RESP;
            end
            S_SHDN:
            begin
                op = OP_SHIFT_DN;
                if (stat.shift_done)
                    state_next = S_RESP;
            end
            S_SHUP:
            begin
                op = OP_SHIFT_UP;
                if (stat.shift_done)
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    op         = OP_PUSH;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a register write always schedules a table reset
        if (cfg_wr_en)
            clr_pend_next = 1'b1;
    end

    assign s_tready = (state_reg == S_IDLE) && !clr_pend_reg;

    // State; table reset is pending after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            clr_pend_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/bffa_dp.sv
`default_nettype none

module bffa_dp
    import bffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dp_op_t                op,
    output dp_stat_t                   stat,
    input  wire logic                  cfg_wr_en,
    input  wire logic [SIZE_W-1:0]     cfg_wr_data,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [MODE_W-1:0]     in_mode,
    output logic [OUT_DATA_W-1:0]      out_data,
    output logic                       out_ok,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [SIZE_W-1:0] MINB   = SIZE_W'(MIN_BLOCK);
    localparam logic [SIZE_W-1:0] BUFMAX = SIZE_W'(BUF_BYTES);

    // Segment table
    seg_t mem [MAX_SEGMENTS];

    // Configuration and bookkeeping
    logic [SIZE_W-1:0] total_reg;
    logic [CW-1:0]     count_reg;
    logic [SIZE_W-1:0] used_reg;

    // Current transaction
    mode_t             mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [SIZE_W-1:0] size_reg;

    // Read pipeline
    logic [CW-1:0]     ptr_reg;
    logic              rd_vld_reg;
    logic [CW-1:0]     rd_idx_reg;
    seg_t              rd_q_reg;

    // Search results
    logic              stop_reg;
    logic              found_reg;
    logic [AW-1:0]     best_idx_reg;
    logic [ADDR_W-1:0] best_start_reg;
    logic [SIZE_W-1:0] best_diff_reg;
    logic [CW-1:0]     idx_reg;
    seg_t              prev_reg;
    seg_t              cur_reg;

    // Merge evaluation
    logic              ml_reg;
    logic              mr_reg;
    logic              full_reg;
    logic [ADDR_W-1:0] ns_reg;
    logic [SIZE_W:0]   ne_reg;
    logic [SIZE_W:0]   old_reg;
    logic [SIZE_W:0]   span_reg;
    logic [SIZE_W:0]   freed_reg;

    // Result and output register
    logic              res_ok_reg;
    logic [ADDR_W-1:0] res_ga_reg;
    logic [SIZE_W-1:0] res_gs_reg;
    logic              out_vld_reg;
    logic              out_ok_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Combinational helpers
    logic [SIZE_W-1:0] eff_total;
    logic [SIZE_W-1:0] in_size;
    logic [SIZE_W:0]   ne0;
    logic              rd_en;
    logic [CW-1:0]     rd_ptr;
    logic [CW-1:0]     ptr_m1;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    seg_t              wr_data;
    logic              shdn_done;
    logic              shup_done;
    logic [SIZE_W-1:0] scan_diff;
    logic [SIZE_W:0]   pe;
    logic              ml;
    logic [SIZE_W:0]   ce;
    logic              mr;
    logic [SIZE_W:0]   span_c;
    logic [SIZE_W+1:0] freed_raw;
    logic              drop;
    logic [SIZE_W-1:0] gs;
    logic [SIZE_W-1:0] used_add;
    logic [SIZE_W-1:0] used_sub;
    logic [SIZE_W-1:0] in_req;

    assign eff_total = (total_reg > BUFMAX) ? BUFMAX : total_reg;
    assign in_req    = in_data[ADDR_W +: SIZE_W];
    assign in_size   = (in_req < MINB) ? MINB : in_req;
    assign ne0       = {1'b0, addr_reg} + {1'b0, size_reg};
    assign ptr_m1    = ptr_reg - 1'b1;
    assign shdn_done = !rd_vld_reg && (ptr_reg >= count_reg);
    assign shup_done = !rd_vld_reg && (ptr_reg <= idx_reg);
    assign scan_diff = rd_q_reg.len - size_reg;
    assign drop      = best_diff_reg < MINB;
    assign gs        = drop ? (size_reg + best_diff_reg) : size_reg;
    assign used_add  = used_reg + gs;
    assign used_sub  = (used_reg > freed_reg[SIZE_W-1:0] || freed_reg[SIZE_W])
                     ? ((freed_reg[SIZE_W]) ? '0 : used_reg - freed_reg[SIZE_W-1:0])
                     : '0;

    // Neighbor checks of a free
    assign pe = {1'b0, prev_reg.len} + {2'b0, prev_reg.start};
    assign ml = (idx_reg != '0)
             && ({{(SIZE_W+2-ADDR_W){1'b0}}, addr_reg} < ({1'b0, pe} + (SIZE_W+2)'(MIN_BLOCK)));
    assign ce = {1'b0, cur_reg.len} + {2'b0, cur_reg.start};
    assign mr = (idx_reg < count_reg)
             && ({{(SIZE_W+2-ADDR_W){1'b0}}, cur_reg.start}
                 < ({1'b0, ne_reg} + (SIZE_W+2)'(MIN_BLOCK)));
    assign span_c    = ne_reg - {2'b0, ns_reg};
    assign freed_raw = {1'b0, span_c} - {1'b0, old_reg};

    // Table read port select
    always_comb
    begin
        rd_en  = 1'b0;
        rd_ptr = ptr_reg;
        case (op)
            OP_SCAN:     rd_en = (ptr_reg < count_reg) && !stop_reg;
            OP_SHIFT_DN: rd_en = (ptr_reg < count_reg);
            OP_SHIFT_UP:
            begin
                rd_en  = (ptr_reg > idx_reg);
                rd_ptr = ptr_m1;
            end
            default:     rd_en = 1'b0;
        endcase
    end

    // Table write port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '{len: eff_total, start: '0};
        case (op)
            OP_CLEAR, OP_CLEAR_OK:
            begin
                wr_en = 1'b1;
            end
            OP_ALLOC_FIN:
            begin
                wr_en   = found_reg && !drop;
                wr_addr = best_idx_reg;
                wr_data = '{len: best_diff_reg, start: best_start_reg + size_reg[ADDR_W-1:0]};
            end
            OP_FREE_D:
            begin
                if (!full_reg && ml_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(idx_reg - 1'b1);
                    wr_data = '{len: span_reg[SIZE_W-1:0], start: prev_reg.start};
                end
                else if (!full_reg && mr_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = '{len: span_reg[SIZE_W-1:0], start: ns_reg};
                end
            end
            OP_SHIFT_DN:
            begin
                wr_en   = rd_vld_reg;
                wr_addr = AW'(rd_idx_reg - 1'b1);
                wr_data = rd_q_reg;
            end
            OP_SHIFT_UP:
            begin
                if (rd_vld_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = AW'(rd_idx_reg + 1'b1);
                    wr_data = rd_q_reg;
                end
                else if (shup_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = idx_reg[AW-1:0];
                    wr_data = '{len: span_reg[SIZE_W-1:0], start: ns_reg};
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Segment memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_q_reg <= mem[rd_ptr[AW-1:0]];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= SIZE_W'(BUF_BYTES);
            count_reg   <= '0;
            used_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= rd_en;
            if (cfg_wr_en)
                total_reg <= cfg_wr_data;
            // output register: loaded on push, emptied when taken
            if (op == OP_PUSH)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            case (op)
                OP_CLEAR, OP_CLEAR_OK:
                begin
                    count_reg <= (eff_total != '0) ? CW'(1) : '0;
                    used_reg  <= '0;
                end
                OP_ALLOC_FIN:
                begin
                    if (found_reg)
                        used_reg <= used_add;
                end
                OP_FREE_D:
                begin
                    if (!full_reg)
                        used_reg <= used_sub;
                end
                OP_SHIFT_DN:
                begin
                    if (shdn_done)
                        count_reg <= count_reg - 1'b1;
                end
                OP_SHIFT_UP:
                begin
                    if (shup_done)
                        count_reg <= count_reg + 1'b1;
                end
                default:
                begin
                    count_reg <= count_reg;
                end
            endcase
        end
    end

    // Working registers of one transaction
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_idx_reg <= rd_ptr;
        case (op)
            OP_LOAD:
            begin
                mode_reg <= mode_t'(in_mode);
                addr_reg <= in_data[ADDR_W-1:0];
                size_reg <= in_size;
            end
            OP_FAIL:
            begin
                res_ok_reg <= 1'b0;
                res_ga_reg <= '0;
                res_gs_reg <= '0;
            end
            OP_CLEAR_OK:
            begin
                res_ok_reg <= 1'b1;
                res_ga_reg <= '0;
                res_gs_reg <= '0;
            end
            OP_SCAN_INIT:
            begin
                ptr_reg   <= '0;
                stop_reg  <= 1'b0;
                found_reg <= 1'b0;
                idx_reg   <= '0;
            end
            OP_SCAN:
            begin
                if (rd_en)
                    ptr_reg <= ptr_reg + 1'b1;
                if (rd_vld_reg && !stop_reg)
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        // walk to the first segment at or above the block
                        if (rd_q_reg.start < addr_reg)
                        begin
                            prev_reg <= rd_q_reg;
                            idx_reg  <= rd_idx_reg + 1'b1;
                        end
                        else
                        begin
                            cur_reg  <= rd_q_reg;
                            idx_reg  <= rd_idx_reg;
                            stop_reg <= 1'b1;
                        end
                    end
                    else if (rd_q_reg.len >= size_reg)
                    begin
                        // best fit, earliest wins ties, exact fit ends search
                        if (!found_reg || scan_diff < best_diff_reg)
                        begin
                            found_reg      <= 1'b1;
                            best_idx_reg   <= rd_idx_reg[AW-1:0];
                            best_start_reg <= rd_q_reg.start;
                            best_diff_reg  <= scan_diff;
                            if (scan_diff == '0)
                                stop_reg <= 1'b1;
                        end
                    end
                end
            end
            OP_ALLOC_FIN:
            begin
                res_ok_reg <= found_reg;
                res_ga_reg <= found_reg ? best_start_reg : '0;
                res_gs_reg <= found_reg ? gs : '0;
                ptr_reg    <= CW'(best_idx_reg) + 1'b1;
            end
            OP_FREE_A:
            begin
                ml_reg  <= ml;
                ns_reg  <= ml ? prev_reg.start : addr_reg;
                ne_reg  <= (ml && pe > ne0) ? pe : ne0;
                old_reg <= ml ? {1'b0, prev_reg.len} : '0;
            end
            OP_FREE_B:
            begin
                mr_reg   <= mr;
                ne_reg   <= (mr && ce > ne_reg) ? ce : ne_reg;
                old_reg  <= old_reg + (mr ? {1'b0, cur_reg.len} : '0);
                full_reg <= !ml_reg && !mr && (count_reg >= CW'(MAX_SEGMENTS));
            end
            OP_FREE_C:
            begin
                span_reg  <= span_c;
                freed_reg <= freed_raw[SIZE_W+1] ? '0 : freed_raw[SIZE_W:0];
            end
            OP_FREE_D:
            begin
                res_ok_reg <= !full_reg;
                res_ga_reg <= '0;
                res_gs_reg <= '0;
                ptr_reg    <= (ml_reg && mr_reg) ? (idx_reg + 1'b1) : count_reg;
            end
            OP_SHIFT_DN:
            begin
                if (rd_en)
                    ptr_reg <= ptr_reg + 1'b1;
            end
            OP_SHIFT_UP:
            begin
                if (rd_en)
                    ptr_reg <= ptr_m1;
            end
            OP_PUSH:
            begin
                out_ok_reg   <= res_ok_reg;
                out_data_reg <= {{(OUT_DATA_W-ADDR_W-3*SIZE_W+ SIZE_W){1'b0}},
                                 used_reg, res_gs_reg, res_ga_reg};
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    // Status to the controller
    always_comb
    begin
        stat.mode          = mode_reg;
        stat.alloc_room    = ({1'b0, used_reg} + {1'b0, size_reg}) <= {1'b0, eff_total};
        stat.free_in_range = ne0 <= {1'b0, eff_total};
        stat.scan_done     = stop_reg || (!rd_vld_reg && (ptr_reg >= count_reg));
        stat.found         = found_reg;
        stat.drop          = drop;
        stat.merge_l       = ml_reg;
        stat.merge_r       = mr_reg;
        stat.full          = full_reg;
        // only a free that merges with no neighbor shifts the table up
        stat.shift_done    = (mode_reg == MODE_FREE && !ml_reg && !mr_reg)
                           ? shup_done : shdn_done;
        stat.out_free      = !out_vld_reg || out_ready;
    end

    assign out_valid = out_vld_reg;
    assign out_ok    = out_ok_reg;
    assign out_data  = out_data_reg;

    // Table never grows past its depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_SEGMENTS))
        else $error("segment count exceeds table depth");

    // Every returned read lies inside the live table
    a_read_live: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (rd_idx_reg < count_reg))
        else $error("read beyond live segments");

    // A clear leaves at most one segment and nothing in use
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_CLEAR || op == OP_CLEAR_OK) |=> (count_reg <= CW'(1) && used_reg == '0))
        else $error("clear did not reset the table");

endmodule

`default_nettype wire

>>> hw/rtl/best_fit_free_list_allocator_top.sv
`default_nettype none

// Best-fit allocator over a byte buffer, kept as an address-ordered table of
// free segments in a memory with one write port and one registered read port.
// Each input transaction (allocate, free, clear, or no-op) yields exactly one
// result. Allocate and free walk the table one entry per cycle; an allocate
// stops its walk at an exact fit, a free at the first segment at or above the
// block. Removing or inserting an entry shifts the table one entry per cycle.
// After reset and after every total_size write the table is reset before the
// next transaction is taken. One transaction is in work at a time; a finished
// result waits in the output register while the next transaction is taken.
module best_fit_free_list_allocator_top
    import bffa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [SIZE_W-1:0]     cfg_wr_data,   // total_size
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,       // block_address, request_size
    input  wire logic [MODE_W-1:0]     s_tuser,       // mode
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,       // granted_address, granted_size,
                                                      // used_total
    output logic                       m_tuser        // ok
);

    dp_op_t   op;
    dp_stat_t stat;

    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .cfg_wr_en (cfg_wr_en),
        .stat      (stat),
        .op        (op)
    );

    bffa_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_tdata),
        .in_mode     (s_tuser),
        .out_data    (m_tdata),
        .out_ok      (m_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready)
    );

endmodule

`default_nettype wire
